FILE: rtl/pwg_pkg.sv
// Shared constants and types of the periodic waveform generator.
package pwg_pkg;

  localparam int DEF_PHASE_BITS    = 16;
  localparam int DEF_AMP_FRAC_BITS = 8;

  localparam int TIME_W   = 63;
  localparam int PERIOD_W = 32;
  localparam int AMP_W    = 24;
  localparam int ID_W     = 16;
  localparam int OUT_W    = 34;
  localparam int CFG_IDX_W = 2;
  localparam int BASE_W   = 43;

  localparam logic [TIME_W-1:0]   ORIGIN_RST = 63'd1440449892000000;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 32'd20000000;
  localparam logic [AMP_W-1:0]    AMP_RST    = 24'd2560;
  localparam logic [ID_W-1:0]     ID_RST     = 16'd0;

  // Quarter-wave polynomial coefficients, Q15.
  localparam logic [15:0] SIN_A1 = 16'd51472;
  localparam logic [15:0] SIN_B1 = 16'd21168;
  localparam logic [15:0] SIN_C1 = 16'd2464;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN    = 2'd0,
    REG_PERIOD    = 2'd1,
    REG_AMPLITUDE = 2'd2,
    REG_COMPONENT = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [OUT_W-1:0] saw;
    logic [OUT_W-1:0] square;
    logic [OUT_W-1:0] sine;
  } samples_t;

endpackage

FILE: rtl/pwg_divpipe.sv
// Pipelined restoring division: remainder of the elapsed time and the phase quotient.
module pwg_divpipe #(
  parameter int PHASE_BITS = pwg_pkg::DEF_PHASE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [pwg_pkg::TIME_W-1:0]    in_elapsed,
  input  logic                          in_neg,
  input  logic [pwg_pkg::PERIOD_W-1:0]  period,
  output logic                          out_valid,
  output logic [PHASE_BITS-1:0]         out_phase,
  output logic                          out_neg
);

  localparam int EW = pwg_pkg::TIME_W;
  localparam int PW = pwg_pkg::PERIOD_W;

  // Remainder stages, one dividend bit per stage.
  logic [PW-1:0] rem   [1:EW];
  logic [EW-1:0] dvd   [1:EW];
  logic          rneg  [1:EW];
  logic          rval  [1:EW];

  for (genvar g = 0; g < EW; g++) begin : g_rem
    logic [PW-1:0] rem_i;
    logic [EW-1:0] dvd_i;
    logic          neg_i;
    logic          val_i;
    logic [PW:0]   trial;
    logic          fits;
    if (g == 0) begin : g_first
      assign rem_i = '0;
      assign dvd_i = in_elapsed;
      assign neg_i = in_neg;
      assign val_i = in_valid;
    end else begin : g_next
      assign rem_i = rem[g];
      assign dvd_i = dvd[g];
      assign neg_i = rneg[g];
      assign val_i = rval[g];
    end
    assign trial = {rem_i, dvd_i[EW-1]};
    assign fits  = trial >= {1'b0, period};
    always_ff @(posedge clk) begin
      if (rst) begin
        rval[g+1] <= 1'b0;
      end else if (en) begin
        rval[g+1] <= val_i;
      end
      if (en) begin
        rem[g+1]  <= fits ? PW'(trial - {1'b0, period}) : trial[PW-1:0];
        dvd[g+1]  <= {dvd_i[EW-2:0], 1'b0};
        rneg[g+1] <= neg_i;
      end
    end
  end

  // Quotient stages: phase = floor(rem * 2^PHASE_BITS / period).
  logic [PW-1:0]         qrem [1:PHASE_BITS];
  logic [PHASE_BITS-1:0] quo  [1:PHASE_BITS];
  logic                  qneg [1:PHASE_BITS];
  logic                  qval [1:PHASE_BITS];

  for (genvar j = 0; j < PHASE_BITS; j++) begin : g_quo
    logic [PW-1:0]         qrem_i;
    logic [PHASE_BITS-1:0] quo_i;
    logic                  neg_i;
    logic                  val_i;
    logic [PW:0]           trial;
    logic                  fits;
    if (j == 0) begin : g_first
      assign qrem_i = rem[EW];
      assign quo_i  = '0;
      assign neg_i  = rneg[EW];
      assign val_i  = rval[EW];
    end else begin : g_next
      assign qrem_i = qrem[j];
      assign quo_i  = quo[j];
      assign neg_i  = qneg[j];
      assign val_i  = qval[j];
    end
    assign trial = {qrem_i, 1'b0};
    assign fits  = trial >= {1'b0, period};
    always_ff @(posedge clk) begin
      if (rst) begin
        qval[j+1] <= 1'b0;
      end else if (en) begin
        qval[j+1] <= val_i;
      end
      if (en) begin
        qrem[j+1] <= fits ? PW'(trial - {1'b0, period}) : trial[PW-1:0];
        quo[j+1]  <= {quo_i[PHASE_BITS-2:0], fits};
        qneg[j+1] <= neg_i;
      end
    end
  end

  assign out_valid = qval[PHASE_BITS];
  assign out_phase = quo[PHASE_BITS];
  assign out_neg   = qneg[PHASE_BITS];

endmodule

FILE: rtl/pwg_wave.sv
// Shape generation: quarter-wave sine polynomial, square, sawtooth, scaling and rounding.
module pwg_wave #(
  parameter int PHASE_BITS    = pwg_pkg::DEF_PHASE_BITS,
  parameter int AMP_FRAC_BITS = pwg_pkg::DEF_AMP_FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [PHASE_BITS-1:0]        in_phase,
  input  logic                         in_neg,
  input  logic [pwg_pkg::AMP_W-1:0]    amp,
  input  logic [pwg_pkg::BASE_W-1:0]   base,
  output logic                         out_valid,
  output pwg_pkg::samples_t            out_samples
);

  localparam int QB   = PHASE_BITS - 2;
  localparam int SMAX = (PHASE_BITS > 15) ? PHASE_BITS : 15;
  localparam int VW   = AMP_FRAC_BITS + SMAX + 36;
  localparam int YW   = PHASE_BITS + 1;
  localparam int AW   = pwg_pkg::AMP_W;
  localparam int OW   = pwg_pkg::OUT_W;
  localparam int SN_SH = AMP_FRAC_BITS + 15;
  localparam int SW_SH = AMP_FRAC_BITS + PHASE_BITS;
  localparam logic [VW-1:0] SN_BIAS = VW'(1) << (SN_SH - 1);
  localparam logic [VW-1:0] SW_BIAS = VW'(1) << (SW_SH - 1);
  localparam logic [VW-1:0] SQ_BIAS =
    (AMP_FRAC_BITS > 0) ? (VW'(1) << (AMP_FRAC_BITS - 1)) : '0;
  localparam logic [31:0] SIN_C1_32 = {16'd0, pwg_pkg::SIN_C1};

  // Stage 1: fold the doubled phase into a quarter wave.
  logic [PHASE_BITS-1:0] ang;
  logic [1:0]            quad;
  logic [QB+14:0]        xwide;
  logic [15:0]           xraw;
  assign ang   = {in_phase[PHASE_BITS-2:0], 1'b0};
  assign quad  = ang[PHASE_BITS-1:PHASE_BITS-2];
  assign xwide = {ang[QB-1:0], 15'd0} >> QB;
  assign xraw  = 16'(xwide);

  logic [5:0] v;
  logic [15:0] x1, x2r, x3, x4;
  logic [15:0] sq2, sq3;
  logic [15:0] t3, t4;
  logic [14:0] s5;
  logic        sn1, sn2, sn3, sn4, sn5;
  logic        qn1, qn2, qn3, qn4, qn5;
  logic signed [YW-1:0] sw1, sw2, sw3, sw4, sw5;

  logic [31:0] p_xx, p_ct, p_bt, p_at;
  assign p_xx = x1 * x1;
  assign p_ct = SIN_C1_32 * {16'd0, sq2};
  assign p_bt = sq3 * (pwg_pkg::SIN_B1 - t3);
  assign p_at = x4 * (pwg_pkg::SIN_A1 - t4);

  // Stage 6 and 7 signals.
  logic signed [17:0]      ysn;
  logic signed [AW+17:0]   psn;
  logic signed [AW+YW:0]   psw;
  logic signed [AW:0]      psq;
  logic [VW-1:0]           vsn, vsw, vsq;

  assign ysn = sn5 ? -$signed({3'd0, s5}) : $signed({3'd0, s5});

  assign vsn = VW'(psn) + (VW'(base) << 15) + SN_BIAS;
  assign vsw = VW'(psw) + (VW'(base) << PHASE_BITS) + SW_BIAS;
  assign vsq = VW'(psq) + VW'(base) + SQ_BIAS;

  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      v         <= {v[4:0], in_valid};
      out_valid <= v[5];
    end
    if (en) begin
      // 1: quarter-wave argument and shape signs
      x1  <= quad[0] ? 16'h8000 - xraw : xraw;
      sn1 <= quad[1] ^ in_neg;
      qn1 <= !in_neg && in_phase[PHASE_BITS-1];
      sw1 <= in_neg ? -$signed({1'b0, in_phase}) : $signed({1'b0, in_phase});
      // 2: x^2
      sq2 <= p_xx[30:15];
      x2r <= x1;
      sn2 <= sn1; qn2 <= qn1; sw2 <= sw1;
      // 3: C1 * x^2
      t3  <= p_ct[30:15];
      sq3 <= sq2;
      x3  <= x2r;
      sn3 <= sn2; qn3 <= qn2; sw3 <= sw2;
      // 4: x^2 * (B1 - t)
      t4  <= p_bt[30:15];
      x4  <= x3;
      sn4 <= sn3; qn4 <= qn3; sw4 <= sw3;
      // 5: x * (A1 - t), clamped
      s5  <= (p_at[31:15] > 17'd32767) ? 15'h7FFF : p_at[29:15];
      sn5 <= sn4; qn5 <= qn4; sw5 <= sw4;
      // 6: scale by the amplitude
      psn <= $signed({1'b0, amp}) * ysn;
      psw <= $signed({1'b0, amp}) * sw5;
      psq <= qn5 ? -$signed({1'b0, amp}) : $signed({1'b0, amp});
      // 7: offset and round half up
      out_samples.sine   <= vsn[SN_SH +: OW];
      out_samples.saw    <= vsw[SW_SH +: OW];
      out_samples.square <= vsq[AMP_FRAC_BITS +: OW];
    end
  end

endmodule

FILE: rtl/periodic_waveform_generator_top.sv
// Top level of the periodic waveform generator: registers, pipeline and output skid stage.
// Each 63-bit timestamp word gives one result word of three 34-bit samples: a sine of the
// doubled phase, a square wave and a sawtooth, each scaled by the amplitude, raised by
// (identifier+1)*2*amplitude+1 and rounded half up. Times before the origin use the
// truncated remainder, so the sine and sawtooth flip sign and the square stays high. The
// block takes one word per clock while the skid buffer is empty and is fully pipelined; each
// word passes the input and elapsed-time registers, the restoring divider, which spends one
// stage per bit of the 63-bit elapsed time and one per phase bit, then the shape stages.
// The output register is backed by a one-word skid buffer, so s_tready depends only on local
// state. Configuration must be written only while no word is in flight.
module periodic_waveform_generator_top #(
  parameter int PHASE_BITS    = pwg_pkg::DEF_PHASE_BITS,
  parameter int AMP_FRAC_BITS = pwg_pkg::DEF_AMP_FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  // Configuration write port.
  input  logic                             cfg_we,
  input  logic [pwg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pwg_pkg::TIME_W-1:0]       cfg_data,
  // Input stream. s_tdata: time_us [62:0], zero pad [63].
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [63:0]                      s_tdata,
  // Output stream. m_tdata: sine_value [33:0], square_value [67:34], saw_value [101:68],
  // zero pad [103:102].
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [103:0]                     m_tdata
);

  localparam int TW = pwg_pkg::TIME_W;

  // Configuration registers. Zero writes to the period and amplitude are dropped.
  logic [TW-1:0]                  origin;
  logic [pwg_pkg::PERIOD_W-1:0]   period;
  logic [pwg_pkg::AMP_W-1:0]      amp;
  logic [pwg_pkg::ID_W-1:0]       comp_id;
  logic [pwg_pkg::BASE_W-1:0]     base;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin  <= pwg_pkg::ORIGIN_RST;
      period  <= pwg_pkg::PERIOD_RST;
      amp     <= pwg_pkg::AMP_RST;
      comp_id <= pwg_pkg::ID_RST;
    end else if (cfg_we) begin
      unique case (pwg_pkg::cfg_reg_t'(cfg_index))
        pwg_pkg::REG_ORIGIN: origin <= cfg_data;
        pwg_pkg::REG_PERIOD: begin
          if (cfg_data[31:0] != '0) period <= cfg_data[31:0];
        end
        pwg_pkg::REG_AMPLITUDE: begin
          if (cfg_data[23:0] != '0) amp <= cfg_data[23:0];
        end
        pwg_pkg::REG_COMPONENT: comp_id <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // The offset 2*(id+1)*A + 1 in amplitude units is precomputed from the registers; it
  // settles long before a word written after a configuration change reaches the output.
  logic [40:0] id_amp;
  assign id_amp = ({1'b0, comp_id} + 17'd1) * amp;
  always_ff @(posedge clk) begin
    base <= {id_amp, 1'b0} + (pwg_pkg::BASE_W'(1) << AMP_FRAC_BITS);
  end

  // The whole pipeline advances while the skid buffer is empty.
  logic skid_v;
  logic en;
  assign en       = !skid_v;
  assign s_tready = en;

  // Input register, then the elapsed time and its sign.
  logic          v_in, v_el;
  logic [TW-1:0] t_in, elapsed;
  logic          neg_el;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_in <= 1'b0;
      v_el <= 1'b0;
    end else if (en) begin
      v_in <= s_tvalid;
      v_el <= v_in;
    end
    if (en) begin
      t_in    <= s_tdata[TW-1:0];
      neg_el  <= t_in < origin;
      elapsed <= (t_in < origin) ? origin - t_in : t_in - origin;
    end
  end

  logic                  v_ph, neg_ph;
  logic [PHASE_BITS-1:0] phase;

  pwg_divpipe #(.PHASE_BITS(PHASE_BITS)) u_div (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (v_el),
    .in_elapsed (elapsed),
    .in_neg     (neg_el),
    .period     (period),
    .out_valid  (v_ph),
    .out_phase  (phase),
    .out_neg    (neg_ph)
  );

  logic              v_wave;
  pwg_pkg::samples_t wave;

  pwg_wave #(.PHASE_BITS(PHASE_BITS), .AMP_FRAC_BITS(AMP_FRAC_BITS)) u_wave (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (v_ph),
    .in_phase    (phase),
    .in_neg      (neg_ph),
    .amp         (amp),
    .base        (base),
    .out_valid   (v_wave),
    .out_samples (wave)
  );

  // Output register with a one-word skid buffer behind it.
  pwg_pkg::samples_t out_d, skid_d;
  logic              out_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (out_v && !m_tready) begin
      if (en && v_wave) skid_v <= 1'b1;
    end else if (skid_v) begin
      out_v  <= 1'b1;
      skid_v <= 1'b0;
    end else begin
      out_v  <= v_wave;
    end
    if (out_v && !m_tready) begin
      if (en && v_wave) skid_d <= wave;
    end else if (skid_v) begin
      out_d <= skid_d;
    end else begin
      out_d <= wave;
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = {2'b00, out_d.saw, out_d.square, out_d.sine};

  // A word in the skid buffer always has an occupied output register ahead of it.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> out_v) else $error("skid word without output word");

  // The skid buffer only fills when the output was held back.
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_v) |-> $past(out_v && !m_tready)) else $error("skid filled without stall");

  // A full skid buffer stays full while the output is still held back.
  a_skid_hold: assert property (@(posedge clk) disable iff (rst)
    (skid_v && !m_tready) |=> skid_v) else $error("skid word lost under stall");

endmodule
